// File: hw/rtl/ordered_array_list_engine_core_defines.svh
// Assertion macros for the list engine RTL; the sequencer (oal_seq) includes them.
`ifndef ORDERED_ARRAY_LIST_ENGINE_CORE_DEFINES_SVH
`define ORDERED_ARRAY_LIST_ENGINE_CORE_DEFINES_SVH

// Checked only while out of reset.
`define OAL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define OAL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hw/rtl/oal_pkg.sv
`default_nettype none

package oal_pkg;

  localparam int OalCapacity   = 16;
  localparam int OalMaxResults = 16;
  localparam int OalPosW       = 5;
  localparam int OalKeyW       = 16;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_SEARCH = 2'd2,
    REQ_LIST   = 2'd3
  } oal_req_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SHUP,
    ST_REM_RD,
    ST_REM_CAP,
    ST_SHDN,
    ST_SRCH,
    ST_LST_RD,
    ST_LST_OUT,
    ST_RESP
  } oal_state_e;

  typedef struct packed {
    oal_req_e             req_type;
    logic [OalPosW-1:0]   position;
    logic                 at_end;
    logic [OalKeyW-1:0]   entry_key;
    logic [OalKeyW-1:0]   entry_data;
    logic [OalPosW-1:0]   list_limit;
  } oal_req_t;

  typedef struct packed {
    logic                 ok;
    logic [3:0]           index_out;
    logic [OalKeyW-1:0]   out_key;
    logic [OalKeyW-1:0]   out_data;
    logic [4:0]           count;
    logic                 empty_res;
    logic                 last;
  } oal_rsp_t;

  typedef struct packed {
    logic [OalKeyW-1:0] key;
    logic [OalKeyW-1:0] data;
  } oal_entry_t;

endpackage

`default_nettype wire

// File: hw/rtl/oal_ram.sv
`default_nettype none

module oal_ram import oal_pkg::*; #(
  parameter int DEPTH = OalCapacity,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic          clk_i,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire oal_entry_t    wr_data_i,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output oal_entry_t         rd_data_o
);

  oal_entry_t mem_q [DEPTH];
  oal_entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// File: hw/rtl/oal_seq.sv
`default_nettype none

module oal_seq import oal_pkg::*; #(
  parameter int CAPACITY = OalCapacity,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  input  wire oal_req_t      req_i,
  output logic               req_ready_o,
  output logic               res_valid_o,
  output oal_rsp_t           res_o,
  input  wire logic          res_ready_i,
  output logic               wr_en_o,
  output logic [AW-1:0]      wr_addr_o,
  output oal_entry_t         wr_data_o,
  output logic               rd_en_o,
  output logic [AW-1:0]      rd_addr_o,
  input  wire oal_entry_t    rd_data_i
);

`include "ordered_array_list_engine_core_defines.svh"

  localparam int CmpW = (CW > OalPosW) ? CW : OalPosW;
  localparam logic [CW-1:0]   CapC = CW'(CAPACITY);
  localparam logic [CmpW-1:0] MaxC = CmpW'(OalMaxResults);

  oal_state_e state_q, state_d;
  logic [CW-1:0] ptr_q, ptr_d, pos_q, pos_d, count_q, count_d, lst_n_q, lst_n_d;
  logic [CW-1:0] chk_idx_q, chk_idx_d, res_idx_q, res_idx_d;
  logic [AW-1:0] wpaddr_q, wpaddr_d;
  logic          wpend_q, wpend_d, chk_q, chk_d, res_ok_q, res_ok_d;
  logic [OalKeyW-1:0] key_q, key_d, data_q, data_d;
  logic [OalKeyW-1:0] res_key_q, res_key_d, res_data_q, res_data_d;

  logic            accept, ins_fail, rem_fail, sh_more, fw_more, hit, lst_last;
  logic [CmpW-1:0] cnt_ext, pos_ext, ins_pos_ext, lim_ext, lst_a, lst_n;

  assign accept      = req_valid_i && (state_q == ST_IDLE);
  assign req_ready_o = (state_q == ST_IDLE);

  assign cnt_ext     = CmpW'(count_q);
  assign pos_ext     = CmpW'(req_i.position);
  assign lim_ext     = CmpW'(req_i.list_limit);
  assign ins_pos_ext = req_i.at_end ? cnt_ext : pos_ext;
  assign ins_fail    = (count_q >= CapC) || (ins_pos_ext > cnt_ext);
  assign rem_fail    = (pos_ext >= cnt_ext);
  assign lst_a       = (cnt_ext < lim_ext) ? cnt_ext : lim_ext;
  assign lst_n       = (lst_a < MaxC) ? lst_a : MaxC;

  assign sh_more  = (ptr_q > pos_q);
  assign fw_more  = (ptr_q < count_q);
  assign hit      = chk_q && (rd_data_i.key == key_q);
  assign lst_last = ((ptr_q + CW'(1)) == lst_n_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (req_i.req_type)
            REQ_INSERT: state_d = ins_fail ? ST_RESP : ST_SHUP;
            REQ_REMOVE: state_d = rem_fail ? ST_RESP : ST_REM_RD;
            REQ_SEARCH: state_d = ST_SRCH;
            REQ_LIST:   state_d = (lst_n == '0) ? ST_RESP : ST_LST_RD;
          endcase
        end
      end
      ST_SHUP: begin
        if (!sh_more && !wpend_q) begin
          state_d = ST_RESP;
        end
      end
      ST_REM_RD:  state_d = ST_REM_CAP;
      ST_REM_CAP: state_d = ST_SHDN;
      ST_SHDN: begin
        if (!fw_more && !wpend_q) begin
          state_d = ST_RESP;
        end
      end
      ST_SRCH: begin
        if (hit || (!fw_more && !chk_q)) begin
          state_d = ST_RESP;
        end
      end
      ST_LST_RD: state_d = ST_LST_OUT;
      ST_LST_OUT: begin
        if (res_ready_i) begin
          state_d = lst_last ? ST_IDLE : ST_LST_RD;
        end
      end
      ST_RESP: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ptr_d      = ptr_q;
    pos_d      = pos_q;
    count_d    = count_q;
    lst_n_d    = lst_n_q;
    chk_idx_d  = chk_idx_q;
    wpaddr_d   = wpaddr_q;
    wpend_d    = wpend_q;
    chk_d      = chk_q;
    key_d      = key_q;
    data_d     = data_q;
    res_ok_d   = res_ok_q;
    res_idx_d  = res_idx_q;
    res_key_d  = res_key_q;
    res_data_d = res_data_q;
    wr_en_o    = 1'b0;
    wr_addr_o  = '0;
    wr_data_o  = '0;
    rd_en_o    = 1'b0;
    rd_addr_o  = '0;
    res_valid_o = 1'b0;
    res_o.ok        = res_ok_q;
    res_o.index_out = 4'(res_idx_q);
    res_o.out_key   = res_key_q;
    res_o.out_data  = res_data_q;
    res_o.count     = 5'(count_q);
    res_o.empty_res = (count_q == '0);
    res_o.last      = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          key_d      = req_i.entry_key;
          data_d     = req_i.entry_data;
          wpend_d    = 1'b0;
          chk_d      = 1'b0;
          res_ok_d   = 1'b0;
          res_idx_d  = '0;
          res_key_d  = '0;
          res_data_d = '0;
          unique case (req_i.req_type)
            REQ_INSERT: begin
              pos_d = CW'(ins_pos_ext);
              ptr_d = count_q;
            end
            REQ_REMOVE: pos_d = CW'(pos_ext);
            REQ_SEARCH: ptr_d = '0;
            REQ_LIST: begin
              ptr_d   = '0;
              lst_n_d = CW'(lst_n);
            end
          endcase
        end
      end
      ST_SHUP: begin
        if (wpend_q) begin
          wr_en_o   = 1'b1;
          wr_addr_o = wpaddr_q;
          wr_data_o = rd_data_i;
        end
        if (sh_more) begin
          rd_en_o   = 1'b1;
          rd_addr_o = AW'(ptr_q - CW'(1));
          wpend_d   = 1'b1;
          wpaddr_d  = AW'(ptr_q);
          ptr_d     = ptr_q - CW'(1);
        end else begin
          wpend_d = 1'b0;
          if (!wpend_q) begin
            wr_en_o        = 1'b1;
            wr_addr_o      = AW'(pos_q);
            wr_data_o.key  = key_q;
            wr_data_o.data = data_q;
            count_d        = count_q + CW'(1);
            res_ok_d       = 1'b1;
            res_idx_d      = pos_q;
          end
        end
      end
      ST_REM_RD: begin
        rd_en_o   = 1'b1;
        rd_addr_o = AW'(pos_q);
        ptr_d     = pos_q + CW'(1);
      end
      ST_REM_CAP: begin
        res_ok_d   = 1'b1;
        res_idx_d  = pos_q;
        res_key_d  = rd_data_i.key;
        res_data_d = rd_data_i.data;
        wpend_d    = 1'b0;
      end
      ST_SHDN: begin
        if (wpend_q) begin
          wr_en_o   = 1'b1;
          wr_addr_o = wpaddr_q;
          wr_data_o = rd_data_i;
        end
        if (fw_more) begin
          rd_en_o   = 1'b1;
          rd_addr_o = AW'(ptr_q);
          wpend_d   = 1'b1;
          wpaddr_d  = AW'(ptr_q - CW'(1));
          ptr_d     = ptr_q + CW'(1);
        end else begin
          wpend_d = 1'b0;
          if (!wpend_q) begin
            count_d = count_q - CW'(1);
          end
        end
      end
      ST_SRCH: begin
        if (hit) begin
          res_ok_d   = 1'b1;
          res_idx_d  = chk_idx_q;
          res_key_d  = rd_data_i.key;
          res_data_d = rd_data_i.data;
        end else if (fw_more) begin
          rd_en_o   = 1'b1;
          rd_addr_o = AW'(ptr_q);
          chk_d     = 1'b1;
          chk_idx_d = ptr_q;
          ptr_d     = ptr_q + CW'(1);
        end else begin
          chk_d = 1'b0;
        end
      end
      ST_LST_RD: begin
        rd_en_o   = 1'b1;
        rd_addr_o = AW'(ptr_q);
      end
      ST_LST_OUT: begin
        res_valid_o     = 1'b1;
        res_o.ok        = 1'b1;
        res_o.index_out = 4'(ptr_q);
        res_o.out_key   = rd_data_i.key;
        res_o.out_data  = rd_data_i.data;
        res_o.last      = lst_last;
        if (res_ready_i) begin
          ptr_d = ptr_q + CW'(1);
        end
      end
      ST_RESP: res_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      wpend_q <= 1'b0;
      chk_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      wpend_q <= wpend_d;
      chk_q   <= chk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q      <= ptr_d;
    pos_q      <= pos_d;
    lst_n_q    <= lst_n_d;
    chk_idx_q  <= chk_idx_d;
    wpaddr_q   <= wpaddr_d;
    key_q      <= key_d;
    data_q     <= data_d;
    res_ok_q   <= res_ok_d;
    res_idx_q  <= res_idx_d;
    res_key_q  <= res_key_d;
    res_data_q <= res_data_d;
  end

  `OAL_ASSERT_ALWAYS(a_count_max, count_q <= CapC, "entry count above capacity")
  `OAL_ASSERT(a_idle_no_res, (state_q == ST_IDLE) |-> !res_valid_o, "result while idle")
  `OAL_ASSERT(a_wr_range, wr_en_o |-> (wr_addr_o < CAPACITY), "write beyond capacity")
  `OAL_ASSERT(a_ins_count, (state_q == ST_SHUP && state_d == ST_RESP) |=> (count_q == $past(count_q) + CW'(1)), "insert did not grow count")

endmodule

`default_nettype wire

// File: hw/rtl/ordered_array_list_engine_core.sv
// Channel  Direction  Handshake                 Word
// req      in         req_valid_i / req_ready_o  req_i (oal_req_t)
// rsp      out        rsp_valid_o / rsp_ready_i  rsp_o (oal_rsp_t)
//
// Insert and remove shift each entry from the request position to the end of the list, so
// their duration grows with count - position; search reads entries in order until a key
// matches, and list reads each entry and waits for its word to be taken before the next.
// A request is taken only while the sequencer is idle; a held result word does not block it.
// Reset clears the entry count; the entry memory needs no clearing pass.
// A stalled result port holds the sequencer in its result state until the word moves on.
`default_nettype none

module ordered_array_list_engine_core import oal_pkg::*; #(
  parameter int CAPACITY = OalCapacity
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     req_valid_i,
  output logic          req_ready_o,
  input  wire oal_req_t req_i,
  output logic          rsp_valid_o,
  input  wire logic     rsp_ready_i,
  output oal_rsp_t      rsp_o
);

  localparam int AW = $clog2(CAPACITY);

  logic          res_valid, res_ready, wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  oal_rsp_t      res, rsp_q, rsp_d;
  oal_entry_t    wr_data, rd_data;
  logic          rsp_valid_q, rsp_valid_d;

  oal_seq #(
    .CAPACITY(CAPACITY)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid_i),
    .req_i      (req_i),
    .req_ready_o(req_ready_o),
    .res_valid_o(res_valid),
    .res_o      (res),
    .res_ready_i(res_ready),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data)
  );

  oal_ram #(
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  assign res_ready = !rsp_valid_q || rsp_ready_i;

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    rsp_d       = rsp_q;
    if (res_valid && res_ready) begin
      rsp_valid_d = 1'b1;
      rsp_d       = res;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

`default_nettype wire

// File: tb/ordered_array_list_engine_core_test.sv
`timescale 1ns / 1ps

module ordered_array_list_engine_core_test import oal_pkg::*;;

  localparam int unsigned RandomItems   = 225;
  localparam int unsigned CalmTail      = 40;
  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned DrainCycles   = 40;

  // Shadow copy of the list that predicts every result word of a request.
  class list_shadow;
    logic [15:0]  key_mem[OalCapacity];
    logic [15:0]  data_mem[OalCapacity];
    int unsigned  fill;
    oal_rsp_t     due_words[$];
    int unsigned  mismatches;
    int unsigned  words_checked;
    int unsigned  full_hits;
    int unsigned  kind_seen[4];

    function new();
      fill = 0;
      mismatches = 0;
      words_checked = 0;
      full_hits = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
    endfunction

    function void push_word(bit ok, int unsigned idx, logic [15:0] k, logic [15:0] d,
                            bit fin);
      oal_rsp_t w;
      w.ok        = ok;
      w.index_out = idx[3:0];
      w.out_key   = k;
      w.out_data  = d;
      w.count     = fill[4:0];
      w.empty_res = (fill == 0);
      w.last      = fin;
      due_words.push_back(w);
    endfunction

    function void note_request(oal_req_t r);
      int unsigned pos;
      int unsigned n;
      int unsigned hit;
      logic [15:0] rk;
      logic [15:0] rd;
      kind_seen[r.req_type]++;
      case (r.req_type)
        REQ_INSERT: begin
          pos = r.at_end ? fill : r.position;
          if (fill >= OalCapacity || pos > fill) begin
            push_word(1'b0, 0, '0, '0, 1'b1);
          end else begin
            for (int unsigned i = fill; i > pos; i--) begin
              key_mem[i]  = key_mem[i - 1];
              data_mem[i] = data_mem[i - 1];
            end
            key_mem[pos]  = r.entry_key;
            data_mem[pos] = r.entry_data;
            fill++;
            if (fill == OalCapacity) full_hits++;
            push_word(1'b1, pos, '0, '0, 1'b1);
          end
        end
        REQ_REMOVE: begin
          pos = r.position;
          if (pos >= fill) begin
            push_word(1'b0, 0, '0, '0, 1'b1);
          end else begin
            rk = key_mem[pos];
            rd = data_mem[pos];
            for (int unsigned i = pos; i + 1 < fill; i++) begin
              key_mem[i]  = key_mem[i + 1];
              data_mem[i] = data_mem[i + 1];
            end
            fill--;
            push_word(1'b1, pos, rk, rd, 1'b1);
          end
        end
        REQ_SEARCH: begin
          hit = fill;
          for (int unsigned i = 0; i < fill; i++) begin
            if (hit == fill && key_mem[i] == r.entry_key) hit = i;
          end
          if (hit < fill) push_word(1'b1, hit, key_mem[hit], data_mem[hit], 1'b1);
          else push_word(1'b0, 0, '0, '0, 1'b1);
        end
        default: begin
          n = fill;
          if (n > r.list_limit) n = r.list_limit;
          if (n > OalMaxResults) n = OalMaxResults;
          if (n == 0) begin
            push_word(1'b0, 0, '0, '0, 1'b1);
          end else begin
            for (int unsigned i = 0; i < n; i++) begin
              push_word(1'b1, i, key_mem[i], data_mem[i], i + 1 == n);
            end
          end
        end
      endcase
    endfunction

    function void check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_word(oal_rsp_t got);
      oal_rsp_t want;
      if (due_words.size() == 0) begin
        $error("result word with nothing pending: %p", got);
        mismatches++;
        return;
      end
      want = due_words.pop_front();
      words_checked++;
      check_field("ok", want.ok, got.ok);
      check_field("index_out", want.index_out, got.index_out);
      check_field("out_key", want.out_key, got.out_key);
      check_field("out_data", want.out_data, got.out_data);
      check_field("count", want.count, got.count);
      check_field("empty_res", want.empty_res, got.empty_res);
      check_field("last", want.last, got.last);
    endfunction
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     req_valid_i;
  logic     req_ready_o;
  oal_req_t req_i;
  logic     rsp_valid_o;
  logic     rsp_ready_i;
  oal_rsp_t rsp_o;

  list_shadow  shadow = new();
  int unsigned reqs_taken;
  int unsigned quiet_cycles;
  bit          calm;
  bit          rsp_stalling;
  int unsigned rsp_span;
  logic [15:0] key_pool[8];

  ordered_array_list_engine_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_valid_i && req_ready_o) begin
        shadow.note_request(req_i);
        reqs_taken++;
      end
      if (rsp_valid_o && rsp_ready_i) begin
        shadow.check_word(rsp_o);
      end
      if ((req_valid_i && req_ready_o) || (rsp_valid_o && rsp_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rsp_span == 0) begin
        rsp_stalling = !calm && !rsp_stalling && ($urandom_range(0, 2) == 0);
        rsp_span = rsp_stalling ? $urandom_range(1, 19) : $urandom_range(1, 40);
      end
      rsp_ready_i = !rsp_stalling;
      rsp_span--;
    end
  end

  initial begin
    wait (rst_ni);
    while (quiet_cycles < WatchdogLimit) @(posedge clk_i);
    $display("Timed out after %0d cycles without a handshake.", quiet_cycles);
    $display("ordered_array_list_engine_core_test failed");
    $finish;
  end

  task automatic send_request(input oal_req_t r);
    int unsigned target;
    int unsigned gap;
    target = reqs_taken + 1;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      req_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_i = r;
    req_valid_i = 1'b1;
    do @(negedge clk_i); while (reqs_taken != target);
  endtask

  task automatic issue(input oal_req_e kind, input int unsigned pos, input bit tail,
                       input logic [15:0] k, input logic [15:0] d,
                       input int unsigned lim);
    oal_req_t r;
    r.req_type   = kind;
    r.position   = pos[4:0];
    r.at_end     = tail;
    r.entry_key  = k;
    r.entry_data = d;
    r.list_limit = lim[4:0];
    send_request(r);
  endtask

  task automatic run_directed();
    logic [15:0] k;
    logic [15:0] d;
    issue(REQ_LIST, 0, 1'b0, '0, '0, 16);
    issue(REQ_REMOVE, 0, 1'b0, '0, '0, 0);
    issue(REQ_SEARCH, 0, 1'b0, 16'h1234, '0, 0);
    issue(REQ_INSERT, 1, 1'b0, 16'h5555, 16'hAAAA, 0);
    for (int i = 0; i < OalCapacity; i++) begin
      k = (i == 0) ? 16'hFFFF : (i == 1) ? 16'h0000 : 16'($urandom);
      d = (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF : 16'($urandom);
      case (i % 3)
        1: issue(REQ_INSERT, 0, 1'b0, k, d, 0);
        2: issue(REQ_INSERT, $urandom_range(0, i), 1'b0, k, d, 0);
        default: issue(REQ_INSERT, $urandom_range(0, 31), 1'b1, k, d, 0);
      endcase
    end
    issue(REQ_LIST, 0, 1'b0, '0, '0, 31);
    issue(REQ_INSERT, 0, 1'b0, 16'hBEEF, 16'hCAFE, 0);
    issue(REQ_SEARCH, 0, 1'b0, 16'hFFFF, '0, 0);
    issue(REQ_LIST, 0, 1'b0, '0, '0, 0);
    issue(REQ_REMOVE, 31, 1'b0, '0, '0, 0);
    issue(REQ_REMOVE, 15, 1'b0, '0, '0, 0);
    issue(REQ_REMOVE, 0, 1'b0, '0, '0, 0);
  endtask

  task automatic run_random();
    oal_req_t    r;
    int unsigned mode;
    int unsigned epoch_left;
    int unsigned p;
    epoch_left = 0;
    mode = 0;
    for (int unsigned n = 0; n < RandomItems; n++) begin
      if (epoch_left == 0) begin
        mode = $urandom_range(0, 2);
        epoch_left = $urandom_range(15, 40);
      end
      epoch_left--;
      calm = (n + CalmTail >= RandomItems);
      r.position   = 5'($urandom_range(0, 31));
      r.at_end     = 1'($urandom);
      r.entry_key  = 16'($urandom);
      r.entry_data = 16'($urandom);
      r.list_limit = 5'($urandom_range(0, 31));
      p = $urandom_range(0, 99);
      case (mode)
        0: r.req_type = (p < 65) ? REQ_INSERT : (p < 80) ? REQ_SEARCH :
                        (p < 90) ? REQ_LIST : REQ_REMOVE;
        1: r.req_type = (p < 60) ? REQ_REMOVE : (p < 75) ? REQ_INSERT :
                        (p < 90) ? REQ_SEARCH : REQ_LIST;
        default: r.req_type = (p < 25) ? REQ_INSERT : (p < 50) ? REQ_REMOVE :
                              (p < 75) ? REQ_SEARCH : REQ_LIST;
      endcase
      case (r.req_type)
        REQ_INSERT: begin
          r.at_end = ($urandom_range(0, 3) == 0);
          if (!r.at_end && $urandom_range(0, 9) < 8) begin
            r.position = 5'($urandom_range(0, shadow.fill));
          end
          if ($urandom_range(0, 1) == 0) r.entry_key = key_pool[$urandom_range(0, 7)];
        end
        REQ_REMOVE: begin
          if (shadow.fill > 0 && $urandom_range(0, 9) < 8) begin
            r.position = 5'($urandom_range(0, shadow.fill - 1));
          end
        end
        REQ_SEARCH: begin
          if (shadow.fill > 0 && $urandom_range(0, 9) < 6) begin
            r.entry_key = shadow.key_mem[$urandom_range(0, shadow.fill - 1)];
          end else if ($urandom_range(0, 2) == 0) begin
            r.entry_key = key_pool[$urandom_range(0, 7)];
          end
        end
        default: begin
          if ($urandom_range(0, 3) == 0) r.list_limit = 5'd16;
        end
      endcase
      send_request(r);
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    req_valid_i  = 1'b0;
    req_i        = '0;
    rsp_ready_i  = 1'b0;
    rsp_stalling = 1'b0;
    rsp_span     = 0;
    reqs_taken   = 0;
    quiet_cycles = 0;
    calm         = 1'b0;
    foreach (key_pool[i]) key_pool[i] = 16'($urandom);
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    run_directed();
    run_random();
    req_valid_i = 1'b0;

    while (shadow.due_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (shadow.due_words.size() != 0) begin
      $error("%0d result words never arrived", shadow.due_words.size());
    end
    $display("Sent %0d requests (%0d insert, %0d remove, %0d search, %0d list).",
             reqs_taken, shadow.kind_seen[REQ_INSERT], shadow.kind_seen[REQ_REMOVE],
             shadow.kind_seen[REQ_SEARCH], shadow.kind_seen[REQ_LIST]);
    $display("Checked %0d result words; the list filled up %0d times.",
             shadow.words_checked, shadow.full_hits);
    if (shadow.mismatches == 0 && shadow.due_words.size() == 0) begin
      $display("ordered_array_list_engine_core_test passed");
    end else begin
      $display("ordered_array_list_engine_core_test failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/oal_pkg.sv
hw/rtl/oal_ram.sv
hw/rtl/oal_seq.sv
hw/rtl/ordered_array_list_engine_core.sv
tb/ordered_array_list_engine_core_test.sv
